// ----- hdl/kmer_fingerprint_dedup_defines.svh -----
// Assertion macros shared by the k-mer fingerprint dedup RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef KMER_FINGERPRINT_DEDUP_DEFINES_SVH
`define KMER_FINGERPRINT_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define KFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kfd same-cycle check failed");

// Next-cycle implication, disabled during reset
`define KFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kfd next-cycle check failed");

`endif

// ----- hdl/kfd_pkg.sv -----
// Shared types and constants for the k-mer fingerprint dedup block.
// No dependencies; imported by the interfaces and all modules.
package kfd_pkg;

    localparam int MAX_KMER     = 16;
    localparam int MAX_READ_LEN = 65536;

    localparam int CHAR_W = 8;
    localparam int CODE_W = 32;
    localparam int POS_W  = 16;
    localparam int KLEN_W = 5;
    localparam int RUN_W  = 5;

    // Largest usable k and the position saturation point
    localparam int K_TOP = (MAX_KMER < 16) ? ((MAX_KMER < 1) ? 1 : MAX_KMER) : 16;
    localparam int POS_CAP = ((MAX_READ_LEN - 1) < 65535) ? (MAX_READ_LEN - 1) : 65535;

    // Base characters, both cases
    localparam logic [CHAR_W-1:0] CHAR_A_UC = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C_UC = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G_UC = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T_UC = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_A_LC = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_LC = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_LC = 8'h74;

    typedef enum logic [1:0] {
        BASE_A = 2'd0,
        BASE_C = 2'd1,
        BASE_G = 2'd2,
        BASE_T = 2'd3
    } t_base;

    // Decoded character
    typedef struct packed {
        logic  valid;
        t_base code;
    } t_base_info;

endpackage

// ----- hdl/kfd_channels.sv -----
// Valid/ready channel interfaces for input and result words.
// Depends on kfd_pkg.
interface kfd_in_if;
    import kfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] base_char;
    logic              read_start;

    modport source (output valid, output base_char, output read_start, input ready);
    modport sink   (input valid, input base_char, input read_start, output ready);
endinterface

interface kfd_out_if;
    import kfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] kmer_code;
    logic [POS_W-1:0]  start_pos;

    modport source (output valid, output kmer_code, output start_pos, input ready);
    modport sink   (input valid, input kmer_code, input start_pos, output ready);
endinterface

// ----- hdl/kfd_base_decode.sv -----
// Character to 2-bit base decoder, case-insensitive ACGT.
// Depends on kfd_pkg.
module kfd_base_decode (
    input  logic [kfd_pkg::CHAR_W-1:0] i_char,
    output kfd_pkg::t_base_info        o_info
);
    import kfd_pkg::*;

    // Anything outside ACGT/acgt is a break in the run
    always_comb begin
        o_info.valid = 1'b1;
        o_info.code  = BASE_A;
        case (i_char) inside
            CHAR_A_UC, CHAR_A_LC: o_info.code = BASE_A;
            CHAR_C_UC, CHAR_C_LC: o_info.code = BASE_C;
            CHAR_G_UC, CHAR_G_LC: o_info.code = BASE_G;
            CHAR_T_UC, CHAR_T_LC: o_info.code = BASE_T;
            default:              o_info.valid = 1'b0;
        endcase
    end

endmodule

// ----- hdl/kmer_fingerprint_dedup.sv -----
// Top level of the rolling 2-bit k-mer encoder with duplicate suppression.
// Depends on kfd_pkg, kfd_channels, kfd_base_decode and the defines header.
//
// Usage:
//   i_in carries one read character per word (base_char, read_start);
//   read_start marks the first character of a new read and clears the
//   window, run count, position and last-emitted code.
//   o_out carries one k-mer per word (kmer_code, start_pos). A character
//   yields at most one word: only when the last k characters are all
//   bases and the code differs from the previous word of the same read.
//   i_cfg_we/i_cfg_wdata write kmer_len (0 acts as 1, above 16 as 16);
//   write only while the block is empty.
// Timing:
//   A character is captured in an input register, then processed into the
//   output register, where its result word, if any, is registered. One
//   character per cycle is sustained while o_out.ready stays high; the
//   combinational state update (shift, compare, counters) sets that.
// Stall: when o_out.ready is low the result word holds; one more character
//   is taken into the input register, then i_in.ready drops.
// Reset: synchronous active-low i_rst_n empties both registers, clears
//   the read state and sets kmer_len to 15.
`include "kmer_fingerprint_dedup_defines.svh"

module kmer_fingerprint_dedup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    kfd_in_if.sink                     i_in,
    kfd_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [kfd_pkg::KLEN_W-1:0] i_cfg_wdata
);
    import kfd_pkg::*;

    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(15);
    localparam logic [KLEN_W-1:0] K_TOP_V    = KLEN_W'(K_TOP);
    localparam logic [POS_W-1:0]  POS_CAP_V  = POS_W'(POS_CAP);
    localparam logic [RUN_W-1:0]  RUN_MAX    = '1;

    // Configuration and read state
    logic [KLEN_W-1:0] r_kmer_len;
    logic [CODE_W-1:0] r_window, n_window;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [POS_W-1:0]  r_char_pos, n_char_pos;
    logic [CODE_W-1:0] r_last, n_last;
    logic              r_emitted_any, n_emitted_any;

    // Input and output registers
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_start;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code, n_out_code;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;

    logic              w_proc;
    logic              w_emit;
    logic [KLEN_W-1:0] w_k;
    logic [CODE_W-1:0] w_mask;
    logic [POS_W-1:0]  w_cur;
    logic [POS_W-1:0]  w_km1;
    t_base_info        w_base;

    kfd_base_decode u_decode (
        .i_char (r_in_char),
        .o_info (w_base)
    );

    // Handshake: process when the output slot is free or being drained
    assign w_proc      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_proc;
    assign o_out.valid = r_out_valid;
    assign o_out.kmer_code = r_out_code;
    assign o_out.start_pos = r_out_pos;

    // Effective k and window mask (shift by 32 gives an all-ones mask)
    always_comb begin
        w_k = r_kmer_len;
        if (w_k == '0) begin
            w_k = KLEN_W'(1);
        end else if (w_k > K_TOP_V) begin
            w_k = K_TOP_V;
        end
        w_mask = ~({CODE_W{1'b1}} << {w_k, 1'b0});
        w_km1  = POS_W'(w_k - KLEN_W'(1));
    end

    // Next read state and result word
    always_comb begin
        n_window      = r_in_start ? '0 : r_window;
        n_run         = r_in_start ? '0 : r_run;
        n_last        = r_in_start ? '0 : r_last;
        n_emitted_any = r_in_start ? 1'b0 : r_emitted_any;
        w_cur         = r_in_start ? '0 : r_char_pos;
        n_char_pos    = (w_cur < POS_CAP_V) ? w_cur + POS_W'(1) : w_cur;
        w_emit        = 1'b0;
        n_out_code    = n_window & w_mask;
        n_out_pos     = (w_cur >= w_km1) ? w_cur - w_km1 : '0;

        if (!w_base.valid) begin
            n_run = '0;
        end else begin
            n_window   = {n_window[CODE_W-3:0], w_base.code};
            n_out_code = n_window & w_mask;
            if (n_run != RUN_MAX) begin
                n_run = n_run + RUN_W'(1);
            end
            if (n_run >= w_k && (!n_emitted_any || n_out_code != n_last)) begin
                w_emit        = r_in_valid;
                n_last        = n_out_code;
                n_emitted_any = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len    <= KLEN_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_window      <= '0;
            r_run         <= '0;
            r_char_pos    <= '0;
            r_last        <= '0;
            r_emitted_any <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kmer_len <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_proc) begin
                r_out_valid   <= w_emit;
                r_window      <= n_window;
                r_run         <= n_run;
                r_char_pos    <= n_char_pos;
                r_last        <= n_last;
                r_emitted_any <= n_emitted_any;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char  <= i_in.base_char;
            r_in_start <= i_in.read_start;
        end
        if (w_proc && w_emit) begin
            r_out_code <= n_out_code;
            r_out_pos  <= n_out_pos;
        end
    end

    // Checks
    `KFD_ASSERT_NEXT(a_emit_updates_last, i_clk, i_rst_n, w_proc && w_emit,
        r_out_valid && r_emitted_any && r_last == r_out_code)
    `KFD_ASSERT_NOW(a_emit_needs_full_run, i_clk, i_rst_n, w_emit, n_run >= w_k)
    `KFD_ASSERT_NEXT(a_start_restarts_pos, i_clk, i_rst_n, w_proc && r_in_start,
        r_char_pos == POS_W'(1) || POS_CAP_V == '0)
    `KFD_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !i_in.ready,
        r_in_valid && r_out_valid && !o_out.ready)

endmodule
